// ===== rtl/core/sorted_counted_key_table_core_defines.svh =====
// Assertion macros for the sorted counted key table core
`ifndef SORTED_COUNTED_KEY_TABLE_CORE_DEFINES_SVH
`define SORTED_COUNTED_KEY_TABLE_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define SCKT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SCKT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SCKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sckt_pkg.sv =====
// Types and constants shared by the sorted counted key table core
`default_nettype none

package sckt_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int ACTION_W     = 2;
    localparam int KEY_W        = 31;
    localparam int CNT_W        = 16;
    localparam int STATUS_W     = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LIST   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_DECR     = 3'd3,
        ST_DELETED  = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_ENTRY    = 3'd6,
        ST_EMPTY    = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_LIST
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_LOAD_EXT,
        CELL_DECR
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      cmp_en;
        logic      in_range;
    } cell_ctrl_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cell_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/sckt_req_if.sv =====
// Request channel of the sorted counted key table core
`default_nettype none

interface sckt_req_if
    import sckt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [CNT_W-1:0]    start_count;

    modport source (output valid, output action, output key, output start_count,
                    input ready);
    modport sink   (input valid, input action, input key, input start_count,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sckt_rsp_if.sv =====
// Result channel of the sorted counted key table core
`default_nettype none

interface sckt_rsp_if
    import sckt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    entry_key;
    logic [CNT_W-1:0]    entry_count;
    logic                last;

    modport source (output valid, output status, output entry_key, output entry_count,
                    output last, input ready);
    modport sink   (input valid, input status, input entry_key, input entry_count,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sorted_counted_key_table_core.sv =====
// Sorted counted key table: a chain of CAPACITY slots kept in ascending key
// order. Every slot compares its key against a request on the cycle the
// request is taken; once the output register is free, the chain shifts one
// place (insert or delete) or one slot decrements, and the result enters the
// output register. List gives one entry per cycle while the output register
// is free, as the chain rotates through its occupied slots and ends back in
// order. A new request is taken once the update or list walk is done, even
// while the last result waits in the output register.
`default_nettype none
`include "sorted_counted_key_table_core_defines.svh"

module sorted_counted_key_table_core
    import sckt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    sckt_req_if.sink   req,
    sckt_rsp_if.source rsp
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    state_t            state_reg, state_next;
    action_t           act_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [OCC_W-1:0]  list_cnt_reg, list_cnt_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic              out_last_reg, out_last_next;
    logic              out_load;

    logic [KEY_W-1:0]  cell_key [CAPACITY];
    logic [CNT_W-1:0]  cell_cnt [CAPACITY];
    logic [KEY_W-1:0]  left_key [CAPACITY];
    logic [CNT_W-1:0]  left_cnt [CAPACITY];
    logic [KEY_W-1:0]  right_key [CAPACITY];
    logic [CNT_W-1:0]  right_cnt [CAPACITY];
    cell_flags_t       cell_flags [CAPACITY];
    cell_ctrl_t        cell_ctrl [CAPACITY];
    logic [CAPACITY-1:0] lt_vec, eq_vec, prev_lt;

    logic [KEY_W-1:0]  ext_key;
    logic [CNT_W-1:0]  ext_cnt;
    logic [CNT_W-1:0]  sel_cnt;
    logic              req_fire, out_free, upd_fire, list_fire;
    logic              found, full, do_ins, do_del;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign upd_fire  = (state_reg == S_UPD) && out_free;
    assign list_fire = (state_reg == S_LIST) && out_free;

    // ---------------------------------------------------------------- chain
    assign ext_key = (state_reg == S_LIST) ? cell_key[0] : key_reg;
    assign ext_cnt = (state_reg == S_LIST) ? cell_cnt[0] : cnt_reg;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign left_key[g] = ext_key;
            assign left_cnt[g] = ext_cnt;
        end
        else
        begin : g_mid
            assign left_key[g] = cell_key[g-1];
            assign left_cnt[g] = cell_cnt[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_key[g] = ext_key;
            assign right_cnt[g] = ext_cnt;
        end
        else
        begin : g_body
            assign right_key[g] = cell_key[g+1];
            assign right_cnt[g] = cell_cnt[g+1];
        end

        sckt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[g]),
            .probe_key (req.key),
            .left_key  (left_key[g]),
            .left_cnt  (left_cnt[g]),
            .right_key (right_key[g]),
            .right_cnt (right_cnt[g]),
            .ext_key   (ext_key),
            .ext_cnt   (ext_cnt),
            .key       (cell_key[g]),
            .cnt       (cell_cnt[g]),
            .flags     (cell_flags[g])
        );

        assign lt_vec[g] = cell_flags[g].lt;
        assign eq_vec[g] = cell_flags[g].eq;
    end

    // slot i lies past the insert point when slot i-1 is not below the key
    assign prev_lt = {lt_vec[CAPACITY-2:0], 1'b1};

    always_comb
    begin
        sel_cnt = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (eq_vec[i])
            begin
                sel_cnt = sel_cnt | cell_cnt[i];
            end
        end
    end

    assign found  = |eq_vec;
    assign full   = (occ_reg == OCC_W'(CAPACITY));
    assign do_ins = (act_reg == ACT_INSERT) && !found && !full;
    assign do_del = (act_reg == ACT_REMOVE) && found && (sel_cnt <= CNT_W'(1));

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_ctrl[i].cmp_en   = req_fire;
            cell_ctrl[i].in_range = (OCC_W'(i) < occ_reg);
            cell_ctrl[i].cmd      = CELL_HOLD;
            if (upd_fire && do_ins)
            begin
                if (!prev_lt[i])
                begin
                    cell_ctrl[i].cmd = CELL_FROM_LEFT;
                end
                else if (!lt_vec[i])
                begin
                    cell_ctrl[i].cmd = CELL_LOAD_EXT;
                end
            end
            else if (upd_fire && do_del)
            begin
                if (!lt_vec[i])
                begin
                    cell_ctrl[i].cmd = CELL_FROM_RIGHT;
                end
            end
            else if (upd_fire && (act_reg == ACT_REMOVE) && eq_vec[i])
            begin
                cell_ctrl[i].cmd = CELL_DECR;
            end
            else if (list_fire)
            begin
                // rotate the occupied part left; head wraps to the last used slot
                if (OCC_W'(i + 1) < occ_reg)
                begin
                    cell_ctrl[i].cmd = CELL_FROM_RIGHT;
                end
                else if (OCC_W'(i + 1) == occ_reg)
                begin
                    cell_ctrl[i].cmd = CELL_LOAD_EXT;
                end
            end
        end
    end

    // ------------------------------------------------------------ sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (action_t'(req.action) != ACT_NONE))
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    if ((act_reg == ACT_LIST) && (occ_reg != '0))
                    begin
                        state_next = S_LIST;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_LIST:
            begin
                if (out_free && (list_cnt_reg == OCC_W'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        occ_next        = occ_reg;
        list_cnt_next   = list_cnt_reg;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    out_last_next = 1'b1;
                    out_key_next  = key_reg;
                    out_cnt_next  = '0;
                    unique case (act_reg)
                        ACT_INSERT:
                        begin
                            out_load = 1'b1;
                            if (found)
                            begin
                                out_status_next = ST_DUP;
                                out_cnt_next    = sel_cnt;
                            end
                            else if (full)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                out_status_next = ST_INSERTED;
                                out_cnt_next    = cnt_reg;
                                occ_next        = occ_reg + OCC_W'(1);
                            end
                        end
                        ACT_REMOVE:
                        begin
                            out_load = 1'b1;
                            if (!found)
                            begin
                                out_status_next = ST_NOTFOUND;
                            end
                            else if (do_del)
                            begin
                                out_status_next = ST_DELETED;
                                occ_next        = occ_reg - OCC_W'(1);
                            end
                            else
                            begin
                                out_status_next = ST_DECR;
                                out_cnt_next    = sel_cnt - CNT_W'(1);
                            end
                        end
                        ACT_LIST:
                        begin
                            if (occ_reg == '0)
                            begin
                                out_load        = 1'b1;
                                out_status_next = ST_EMPTY;
                                out_key_next    = '0;
                            end
                            else
                            begin
                                list_cnt_next = occ_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = ST_ENTRY;
                    out_key_next    = cell_key[0];
                    out_cnt_next    = cell_cnt[0];
                    out_last_next   = (list_cnt_reg == OCC_W'(1));
                    list_cnt_next   = list_cnt_reg - OCC_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            list_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            list_cnt_reg  <= list_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            act_reg <= action_t'(req.action);
            key_reg <= req.key;
            cnt_reg <= req.start_count;
        end
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_cnt_reg    <= out_cnt_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_key   = out_key_reg;
    assign rsp.entry_count = out_cnt_reg;
    assign rsp.last        = out_last_reg;

    // ----------------------------------------------------------- assertions
    `SCKT_ASSERT_ALWAYS(a_occ_bound, occ_reg <= OCC_W'(CAPACITY), "occupancy above capacity")
    `SCKT_ASSERT_IMPL(a_lt_thermo, state_reg == S_UPD, (lt_vec & ~prev_lt) == '0, "below-key flags not contiguous")
    `SCKT_ASSERT_IMPL(a_key_unique, state_reg == S_UPD, $onehot0(eq_vec), "key matched in more than one slot")
    `SCKT_ASSERT_NEXT(a_occ_quiet, state_reg != S_UPD, $stable(occ_reg), "occupancy moved outside an update")
    `SCKT_ASSERT_IMPL(a_list_len, state_reg == S_LIST, (list_cnt_reg != '0) && (list_cnt_reg <= occ_reg), "list walk count out of range")

endmodule

`default_nettype wire

// ===== rtl/core/sckt_cell.sv =====
// One slot of the sorted key chain: key, count and compare flags
`default_nettype none

module sckt_cell
    import sckt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] probe_key,
    input  logic [KEY_W-1:0] left_key,
    input  logic [CNT_W-1:0] left_cnt,
    input  logic [KEY_W-1:0] right_key,
    input  logic [CNT_W-1:0] right_cnt,
    input  logic [KEY_W-1:0] ext_key,
    input  logic [CNT_W-1:0] ext_cnt,
    output logic [KEY_W-1:0] key,
    output logic [CNT_W-1:0] cnt,
    output cell_flags_t      flags
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    cell_flags_t      flags_reg;

    always_comb
    begin
        key_next = key_reg;
        cnt_next = cnt_reg;
        unique case (ctrl.cmd)
            CELL_HOLD:
            begin
            end
            CELL_FROM_LEFT:
            begin
                key_next = left_key;
                cnt_next = left_cnt;
            end
            CELL_FROM_RIGHT:
            begin
                key_next = right_key;
                cnt_next = right_cnt;
            end
            CELL_LOAD_EXT:
            begin
                key_next = ext_key;
                cnt_next = ext_cnt;
            end
            CELL_DECR:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        cnt_reg <= cnt_next;
    end

    // flags only mean something for occupied slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (ctrl.cmp_en)
        begin
            flags_reg.lt <= ctrl.in_range && (key_reg < probe_key);
            flags_reg.eq <= ctrl.in_range && (key_reg == probe_key);
        end
    end

    assign key   = key_reg;
    assign cnt   = cnt_reg;
    assign flags = flags_reg;

endmodule

`default_nettype wire

// ===== bench/tb_sorted_counted_key_table_core.sv =====
// Self-checking bench for the sorted counted key table core: request driver, result checker
`default_nettype none

module tb_sorted_counted_key_table_core;
    import sckt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH      = CAPACITY_DEF;
    localparam int POOL_SIZE        = 40;
    localparam int OP_TARGET        = 330;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int SETTLE_CYCLES    = 60;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct {
        action_t          action;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] start_count;
        bit               hold_for_drain;
    } table_req_t;

    typedef struct {
        status_t          status;
        logic [KEY_W-1:0] entry_key;
        logic [CNT_W-1:0] entry_count;
        logic             last;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n;

    sckt_req_if req_ch ();
    sckt_rsp_if rsp_ch ();

    sorted_counted_key_table_core #(.CAPACITY(TABLE_DEPTH)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow copy of the table
    logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
    logic [CNT_W-1:0] shadow_counts [TABLE_DEPTH];
    int               shadow_fill = 0;

    table_req_t    pending_reqs[$];
    table_result_t expected_results[$];
    table_req_t    cur_req;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int queued_ops     = 0;
    int total_reqs     = 0;
    int requests_taken = 0;
    int errors         = 0;

    // driver pacing
    int burst_left = 0;
    int gap_left   = 0;

    // sink stall pattern
    int sink_mode       = 0;
    int mode_left       = 0;
    int stall_phase     = 0;
    int hold_left       = 0;
    int results_drained = 0;
    bit long_hold_done  = 1'b0;

    int idle_cycles = 0;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic expect_result(input status_t st, input logic [KEY_W-1:0] k,
                                 input logic [CNT_W-1:0] c, input logic lst);
        table_result_t r;
        r.status      = st;
        r.entry_key   = k;
        r.entry_count = c;
        r.last        = lst;
        expected_results.push_back(r);
    endtask

    // first slot whose key is not below k
    function automatic int slot_for(input logic [KEY_W-1:0] k);
        int i;
        i = 0;
        while (i < shadow_fill && shadow_keys[i] < k)
            i++;
        return i;
    endfunction

    task automatic predict_table_op(input table_req_t r);
        int pos;
        int i;
        case (r.action)
            ACT_INSERT:
            begin
                pos = slot_for(r.key);
                if (pos < shadow_fill && shadow_keys[pos] == r.key)
                    expect_result(ST_DUP, r.key, shadow_counts[pos], 1'b1);
                else if (shadow_fill >= TABLE_DEPTH)
                    expect_result(ST_FULL, r.key, '0, 1'b1);
                else
                begin
                    for (i = shadow_fill; i > pos; i--)
                    begin
                        shadow_keys[i]   = shadow_keys[i-1];
                        shadow_counts[i] = shadow_counts[i-1];
                    end
                    shadow_keys[pos]   = r.key;
                    shadow_counts[pos] = r.start_count;
                    shadow_fill++;
                    expect_result(ST_INSERTED, r.key, r.start_count, 1'b1);
                end
            end
            ACT_REMOVE:
            begin
                pos = slot_for(r.key);
                if (pos >= shadow_fill || shadow_keys[pos] != r.key)
                    expect_result(ST_NOTFOUND, r.key, '0, 1'b1);
                else
                begin
                    if (shadow_counts[pos] != 0)
                        shadow_counts[pos]--;
                    if (shadow_counts[pos] != 0)
                        expect_result(ST_DECR, r.key, shadow_counts[pos], 1'b1);
                    else
                    begin
                        for (i = pos; i + 1 < shadow_fill; i++)
                        begin
                            shadow_keys[i]   = shadow_keys[i+1];
                            shadow_counts[i] = shadow_counts[i+1];
                        end
                        shadow_fill--;
                        expect_result(ST_DELETED, r.key, '0, 1'b1);
                    end
                end
            end
            ACT_LIST:
            begin
                if (shadow_fill == 0)
                    expect_result(ST_EMPTY, '0, '0, 1'b1);
                else
                    for (i = 0; i < shadow_fill; i++)
                        expect_result(ST_ENTRY, shadow_keys[i], shadow_counts[i],
                                      i + 1 == shadow_fill);
            end
            default:
            begin
                // unused action: no result, table untouched
            end
        endcase
    endtask

    task automatic add_req(input action_t a, input logic [KEY_W-1:0] k,
                           input logic [CNT_W-1:0] c, input bit hold);
        table_req_t r;
        r.action         = a;
        r.key            = k;
        r.start_count    = c;
        r.hold_for_drain = hold;
        pending_reqs.push_back(r);
        if (a != ACT_NONE)
            queued_ops++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_SIZE-1)];
        return KEY_W'($urandom());
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return CNT_W'($urandom_range(1, 3));
        if (roll < 75)
            return '0;
        if (roll < 90)
            return CNT_W'($urandom());
        return (roll < 95) ? CNT_MAX : CNT_MAX - 1'b1;
    endfunction

    task automatic build_stimulus();
        int episode;
        int j;
        int offset;
        int roll;
        // hand-picked opening sequence
        add_req(ACT_LIST,   '0,        '0,       1'b0); // empty table
        add_req(ACT_REMOVE, 31'd5,     '0,       1'b0); // nothing to find
        add_req(ACT_INSERT, 31'd1000,  16'd2,    1'b0);
        add_req(ACT_INSERT, '0,        '0,       1'b0); // new head, zero count
        add_req(ACT_INSERT, KEY_MAX,   CNT_MAX,  1'b0); // new tail
        add_req(ACT_INSERT, 31'd500,   16'd1,    1'b0); // mid-list
        add_req(ACT_INSERT, 31'd750,   16'd3,    1'b0);
        add_req(ACT_INSERT, 31'd1000,  16'd9,    1'b0); // duplicate
        add_req(ACT_LIST,   KEY_MAX,   CNT_MAX,  1'b0);
        add_req(ACT_REMOVE, '0,        '0,       1'b0); // head at zero count
        add_req(ACT_REMOVE, 31'd500,   '0,       1'b0);
        add_req(ACT_REMOVE, 31'd1000,  '0,       1'b0);
        add_req(ACT_REMOVE, KEY_MAX,   '0,       1'b0);
        add_req(ACT_REMOVE, 31'd999,   '0,       1'b0); // absent, between keys
        add_req(ACT_NONE,   KEY_MAX,   CNT_MAX,  1'b0);
        add_req(ACT_INSERT, 31'h2AAAAAAA, 16'hAAAA, 1'b0);
        add_req(ACT_INSERT, 31'h55555555, 16'h5555, 1'b0);
        add_req(ACT_REMOVE, 31'd750,   '0,       1'b0);
        add_req(ACT_REMOVE, 31'd750,   '0,       1'b0);
        add_req(ACT_REMOVE, 31'd750,   '0,       1'b0);
        add_req(ACT_LIST,   '0,        '0,       1'b0);
        add_req(ACT_REMOVE, 31'd1000,  '0,       1'b0); // head removal
        add_req(ACT_LIST,   '0,        '0,       1'b0);

        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 31'd1;
        key_pool[3] = KEY_MAX - 1'b1;
        for (j = 4; j < POOL_SIZE; j++)
            key_pool[j] = (j % 2) ? key_pool[j-1] + 1'b1 : KEY_W'($urandom());

        // episodes: fill past capacity, mixed traffic, then wind down
        episode = 0;
        while (queued_ops < OP_TARGET)
        begin
            case (episode % 3)
                0:
                begin
                    offset = $urandom_range(0, POOL_SIZE-1);
                    for (j = 0; j < POOL_SIZE; j++)
                    begin
                        roll = $urandom_range(0, 99);
                        if (roll < 88)
                            add_req(ACT_INSERT, key_pool[(j * 7 + offset) % POOL_SIZE],
                                    pick_count(), j == 0);
                        else if (roll < 94)
                            add_req(ACT_REMOVE, pick_key(), CNT_W'($urandom()), j == 0);
                        else
                            add_req(ACT_LIST, KEY_W'($urandom()), CNT_W'($urandom()),
                                    j == 0);
                    end
                    add_req(ACT_LIST, KEY_W'($urandom()), CNT_W'($urandom()), 1'b0);
                end
                1:
                begin
                    for (j = 0; j < 30; j++)
                    begin
                        roll = $urandom_range(0, 99);
                        if (roll < 40)
                            add_req(ACT_INSERT, pick_key(), pick_count(), j == 0);
                        else if (roll < 80)
                            add_req(ACT_REMOVE, pick_key(), CNT_W'($urandom()), j == 0);
                        else if (roll < 95)
                            add_req(ACT_LIST, KEY_W'($urandom()), CNT_W'($urandom()),
                                    j == 0);
                        else
                            add_req(ACT_NONE, KEY_W'($urandom()), CNT_W'($urandom()),
                                    j == 0);
                    end
                end
                default:
                begin
                    for (j = 0; j < 30; j++)
                    begin
                        roll = $urandom_range(0, 99);
                        if (roll < 80)
                            add_req(ACT_REMOVE, key_pool[$urandom_range(0, POOL_SIZE-1)],
                                    CNT_W'($urandom()), j == 0);
                        else if (roll < 90)
                            add_req(ACT_REMOVE, KEY_W'($urandom()), CNT_W'($urandom()),
                                    j == 0);
                        else
                            add_req(ACT_LIST, KEY_W'($urandom()), CNT_W'($urandom()),
                                    j == 0);
                    end
                    add_req(ACT_LIST, KEY_W'($urandom()), CNT_W'($urandom()), 1'b0);
                end
            endcase
            episode++;
        end
    endtask

    // request driver: bursts with random gaps, optional wait for an empty pipe
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.action      <= ACT_NONE;
            req_ch.key         <= '0;
            req_ch.start_count <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_table_op(cur_req);
                requests_taken++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0 &&
                         (!pending_reqs[0].hold_for_drain || expected_results.size() == 0))
                begin
                    cur_req = pending_reqs.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.action      <= cur_req.action;
                    req_ch.key         <= cur_req.key;
                    req_ch.start_count <= cur_req.start_count;
                    if (burst_left > 1)
                        burst_left--;
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        // a long run with no gaps
                        burst_left = $urandom_range(20, 60);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 8);
                    end
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result sink: own stall modes plus one long hold while requests keep coming
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left = 0;
            mode_left = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                results_drained++;
            if (!long_hold_done && results_drained >= 200 && req_ch.valid)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES;
            end
            stall_phase++;
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    sink_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                else
                    mode_left--;
                case (sink_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= (stall_phase % 7) >= 3;
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        table_result_t exp_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result: status %0d key %0h count %0h",
                                          rsp_ch.status, rsp_ch.entry_key,
                                          rsp_ch.entry_count));
            else
            begin
                exp_r = expected_results.pop_front();
                if (rsp_ch.status !== exp_r.status)
                    report_mismatch($sformatf("status %0d, expected %0d (key %0h)",
                                              rsp_ch.status, exp_r.status, exp_r.entry_key));
                if (rsp_ch.entry_key !== exp_r.entry_key)
                    report_mismatch($sformatf("entry_key %0h, expected %0h",
                                              rsp_ch.entry_key, exp_r.entry_key));
                if (rsp_ch.entry_count !== exp_r.entry_count)
                    report_mismatch($sformatf("entry_count %0h, expected %0h (key %0h)",
                                              rsp_ch.entry_count, exp_r.entry_count,
                                              exp_r.entry_key));
                if (rsp_ch.last !== exp_r.last)
                    report_mismatch($sformatf("last %b, expected %b (key %0h)",
                                              rsp_ch.last, exp_r.last, exp_r.entry_key));
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no request or result moved for %0d cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_NONE;
        req_ch.key         = '0;
        req_ch.start_count = '0;
        rsp_ch.ready       = 1'b0;

        build_stimulus();
        total_reqs = pending_reqs.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (requests_taken != total_reqs || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
